// File: hdl/window_filter_blur_or_sobel_assert.svh
// Assertion macros for the window filter block.
// Used by the controller and datapath modules; needs no other file.
`ifndef WINDOW_FILTER_BLUR_OR_SOBEL_ASSERT_SVH
`define WINDOW_FILTER_BLUR_OR_SOBEL_ASSERT_SVH
`ifndef SYNTHESIS
`define WFB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define WFB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define WFB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define WFB_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: hdl/wfb_pkg.sv
// Package for the window filter: widths, register indexes, state and command types.
// Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wfb_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int PIX_W   = 8;
    localparam int OUT_W   = 11;
    localparam int HGT_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ACCUM,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;     // sample configuration for a new frame
        logic take;      // store the accepted item and advance counters
        logic acc_clr;   // clear accumulators and window walk
        logic acc_step;  // add one window element
        logic sq_step;   // one square-root iteration
        logic dv_step;   // one division iteration
        logic emit;      // load the output register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic has_out;   // accepted item produces a result
        logic acc_done;  // last window element added
        logic sq_done;
        logic dv_done;
        logic mode;
    } t_sts;
endpackage
`default_nettype wire

// File: hdl/wfb_if.sv
// Valid/ready stream interface and configuration write interface.
// Depends on wfb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface wfb_in_if import wfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             is_padding;
    modport source (output valid, pixel_in, is_padding, input ready);
    modport sink   (input valid, pixel_in, is_padding, output ready);
endinterface

interface wfb_out_if import wfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pixel_out;
    logic             last_of_frame;
    modport source (output valid, pixel_out, last_of_frame, input ready);
    modport sink   (input valid, pixel_out, last_of_frame, output ready);
endinterface

interface wfb_cfg_if import wfb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/wfb_ctrl.sv
// Controller state machine of the window filter.
// Depends on wfb_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "window_filter_blur_or_sobel_assert.svh"
module wfb_ctrl import wfb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_busy,
    input  wire  i_first,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = i_first;
                    n_state     = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.take    = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state       = i_sts.has_out ? ST_ACCUM : ST_IDLE;
            end
            ST_ACCUM: begin
                o_cmd.acc_step = 1'b1;
                if (i_sts.acc_done) begin
                    n_state = i_sts.mode ? ST_SQRT : ST_DIV;
                end
            end
            ST_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.dv_step = 1'b1;
                if (i_sts.dv_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `WFB_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE)
    `WFB_ASSERT_NXT(a_accept_write, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == ST_WRITE)
    `WFB_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, !i_out_busy)
endmodule
`default_nettype wire

// File: hdl/wfb_dp.sv
// Datapath of the window filter: configuration, line store, window walk,
// square root and divider units, output register. Depends on wfb_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "window_filter_blur_or_sobel_assert.svh"
module wfb_dp import wfb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire                  i_in_fire,
    input  wire [PIX_W-1:0]      i_pixel_in,
    input  wire                  i_is_padding,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_first,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [OUT_W-1:0]     o_pixel_out,
    output logic                 o_last_of_frame
);
    localparam int ROWS   = MAX_KERNEL + 1;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int DEPTH  = ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int POSW   = WW + HGT_W + 1;
    localparam int SUMW   = PIX_W + 2 * KW;
    localparam int SQW    = 24;

    // Configuration registers.
    logic             r_mode;
    logic [2:0]       r_ksz;
    logic [10:0]      r_wid;
    logic [HGT_W-1:0] r_hgt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_ksz  <= 3'd3;
            r_wid  <= 11'd1024;
            r_hgt  <= 13'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[0];
                REG_KERNEL: begin
                    if (i_cfg_data[0] && 32'(i_cfg_data[2:0]) <= MAX_KERNEL) begin
                        r_ksz <= i_cfg_data[2:0];
                    end
                end
                REG_WIDTH:  r_wid <= i_cfg_data[10:0];
                REG_HEIGHT: r_hgt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame-latched configuration.
    logic             r_fm;
    logic [KW-1:0]    r_fk;
    logic [KW-1:0]    r_frad;
    logic [WW-1:0]    r_fw;
    logic [HGT_W-1:0] r_fh;
    logic [POSW-1:0]  r_delay;
    logic [POSW-1:0]  r_total;
    logic [WW-1:0]    n_w;
    logic [HGT_W-1:0] n_h;
    logic [KW-1:0]    n_rad;
    always_comb begin
        if (r_wid == 11'd0) begin
            n_w = WW'(1);
        end else if (32'(r_wid) > MAX_WIDTH) begin
            n_w = WW'(MAX_WIDTH);
        end else begin
            n_w = WW'(r_wid);
        end
        if (r_hgt == '0) begin
            n_h = HGT_W'(1);
        end else if (r_hgt > HEIGHT_LIMIT) begin
            n_h = HEIGHT_LIMIT;
        end else begin
            n_h = r_hgt;
        end
        n_rad = r_mode ? KW'(1) : KW'((r_ksz - 3'd1) >> 1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm    <= 1'b0;
            r_fk    <= KW'(3);
            r_frad  <= KW'(1);
            r_fw    <= WW'(MAX_WIDTH);
            r_fh    <= 13'd1024;
            r_delay <= POSW'(MAX_WIDTH + 1);
            r_total <= POSW'(MAX_WIDTH * 1024);
        end else if (i_cmd.latch) begin
            r_fm    <= r_mode;
            r_fk    <= KW'(r_ksz);
            r_frad  <= n_rad;
            r_fw    <= n_w;
            r_fh    <= n_h;
            r_delay <= POSW'(n_rad) * POSW'(n_w) + POSW'(n_rad);
            r_total <= POSW'(n_w) * POSW'(n_h);
        end
    end

    // Input raster counters, output position counters.
    logic [WW-1:0]    r_col;
    logic [HGT_W:0]   r_row;
    logic [POSW-1:0]  r_pos;
    logic [WW-1:0]    r_ox;
    logic [HGT_W-1:0] r_oy;
    logic [PIX_W-1:0] r_pix;
    logic             r_pad;
    logic             r_last;
    logic             w_has_out;
    logic             w_last;
    assign o_first   = (r_row == '0) && (r_col == '0);
    assign w_has_out = r_pos >= r_delay;
    assign w_last    = (r_pos - r_delay) == (r_total - POSW'(1));
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_pix <= i_pixel_in;
            r_pad <= i_is_padding;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pos <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (i_cmd.take) begin
            if (w_has_out && w_last) begin
                r_col <= '0;
                r_row <= '0;
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + POSW'(1);
                if (r_col + WW'(1) >= r_fw) begin
                    r_col <= '0;
                    r_row <= r_row + (HGT_W+1)'(1);
                end else begin
                    r_col <= r_col + WW'(1);
                end
            end
        end else if (i_cmd.emit) begin
            // Advance the output position; wrap to the frame start at the end.
            if (r_last) begin
                r_ox <= '0;
                r_oy <= '0;
            end else if (r_ox + WW'(1) >= r_fw) begin
                r_ox <= '0;
                r_oy <= r_oy + HGT_W'(1);
            end else begin
                r_ox <= r_ox + WW'(1);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_last <= w_last;
        end
    end
    assign o_sts.has_out = w_has_out;
    assign o_sts.mode    = r_fm;

    // Row slot mapping: row modulo ROWS.
    logic [RW-1:0] r_wslot;
    logic [RW-1:0] r_oslot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_oslot <= '0;
        end else begin
            if (i_cmd.take && !(w_has_out && w_last) && (r_col + WW'(1) >= r_fw)) begin
                r_wslot <= (32'(r_wslot) == ROWS - 1) ? '0 : r_wslot + RW'(1);
            end else if (i_cmd.take && w_has_out && w_last) begin
                r_wslot <= '0;
            end
            if (i_cmd.emit) begin
                if (r_last) begin
                    r_oslot <= '0;
                end else if (r_ox + WW'(1) >= r_fw) begin
                    r_oslot <= (32'(r_oslot) == ROWS - 1) ? '0 : r_oslot + RW'(1);
                end
            end
        end
    end

    // Line store memory, one write and one read port.
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    assign w_we    = i_cmd.take && (r_row < (HGT_W+1)'(r_fh));
    assign w_waddr = AW'(32'(r_wslot) * MAX_WIDTH + 32'(r_col));
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_pad ? '0 : r_pix;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Window walk: one element issued per cycle; the read data is registered before it is used.
    logic signed [KW:0]   r_dy, r_dx;
    logic                 r_vld1;
    logic                 r_in1;
    logic signed [2:0]    r_cx1, r_cy1;
    logic                 r_walk_end;
    logic                 r_walk_end1;
    logic signed [HGT_W+1:0] w_yy;
    logic signed [WW+1:0]    w_xx;
    logic                    w_inside;
    logic [RW-1:0]           w_rslot;
    logic signed [RW+1:0]    w_st;
    logic signed [KW:0]      w_rad;
    assign w_rad    = (KW+1)'(r_frad);
    assign w_yy     = (HGT_W+2)'(r_oy) + (HGT_W+2)'(r_dy);
    assign w_xx     = (WW+2)'(r_ox) + (WW+2)'(r_dx);
    assign w_inside = (w_yy >= 0) && (w_xx >= 0) && (w_yy < (HGT_W+2)'(r_fh))
                      && (w_xx < (WW+2)'(r_fw));
    always_comb begin
        w_st = (RW+2)'(r_oslot) + (RW+2)'(r_dy);
        if (w_st < 0) begin
            w_st = w_st + (RW+2)'(ROWS);
        end else if (w_st >= (RW+2)'(ROWS)) begin
            w_st = w_st - (RW+2)'(ROWS);
        end
        w_rslot = RW'(w_st);
    end
    assign w_raddr = w_inside ? AW'(32'(w_rslot) * MAX_WIDTH + 32'(w_xx[CW-1:0])) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dy <= '0;
            r_dx <= '0;
            r_vld1 <= 1'b0;
            r_walk_end <= 1'b0;
            r_walk_end1 <= 1'b0;
        end else if (i_cmd.acc_clr) begin
            r_dy <= -w_rad;
            r_dx <= -w_rad;
            r_vld1 <= 1'b0;
            r_walk_end <= 1'b0;
            r_walk_end1 <= 1'b0;
        end else if (i_cmd.acc_step) begin
            r_vld1 <= !r_walk_end;
            r_walk_end1 <= r_walk_end;
            if (!r_walk_end) begin
                if (r_dx == w_rad) begin
                    r_dx <= -w_rad;
                    if (r_dy == w_rad) begin
                        r_walk_end <= 1'b1;
                    end else begin
                        r_dy <= r_dy + (KW+1)'(1);
                    end
                end else begin
                    r_dx <= r_dx + (KW+1)'(1);
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_in1 <= w_inside;
        r_cx1 <= 3'(r_dx);
        r_cy1 <= 3'(r_dy);
    end

    // Accumulators for sum, gx and gy.
    logic [SUMW-1:0]     r_sum;
    logic signed [11:0]  r_gx, r_gy;
    logic signed [11:0]  w_p;
    logic signed [2:0]   w_cx, w_cy;
    assign w_p = r_in1 ? 12'(r_rd) : 12'sd0;
    always_comb begin
        // Sobel coefficients follow from the offsets directly.
        w_cx = (r_cy1 == 3'sd0) ? 3'(r_cx1 * 2) : r_cx1;
        w_cy = (r_cx1 == 3'sd0) ? 3'(r_cy1 * 2) : r_cy1;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_sum <= '0;
            r_gx  <= '0;
            r_gy  <= '0;
        end else if (i_cmd.acc_step && r_vld1) begin
            r_sum <= r_sum + SUMW'(w_p);
            r_gx  <= r_gx + 12'(w_cx * w_p);
            r_gy  <= r_gy + 12'(w_cy * w_p);
        end
    end
    assign o_sts.acc_done = i_cmd.acc_step && r_walk_end1;

    // Integer square root, one result bit per step from two radicand bits.
    logic [SQW-1:0] r_sv, r_sres, r_sbit;
    logic           r_sq_busy;
    logic [10:0]    w_agx, w_agy;
    logic [SQW-1:0] w_gx2, w_gy2;
    // Magnitudes of the gradients stay below 1024, so the squares fit easily.
    assign w_agx = r_gx[11] ? 11'(-r_gx) : 11'(r_gx);
    assign w_agy = r_gy[11] ? 11'(-r_gy) : 11'(r_gy);
    assign w_gx2 = SQW'(w_agx) * SQW'(w_agx);
    assign w_gy2 = SQW'(w_agy) * SQW'(w_agy);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (i_cmd.sq_step) begin
            if (!r_sq_busy) begin
                r_sq_busy <= 1'b1;
                r_sv      <= w_gx2 + w_gy2;
                r_sres    <= '0;
                r_sbit    <= SQW'(1) << (SQW - 2);
            end else begin
                if (r_sv >= r_sres + r_sbit) begin
                    r_sv   <= r_sv - (r_sres + r_sbit);
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
                if (r_sbit == SQW'(1)) begin
                    r_sq_busy <= 1'b0;
                end
            end
        end
    end
    assign o_sts.sq_done = i_cmd.sq_step && r_sq_busy && (r_sbit == SQW'(1));

    // Restoring divider, one quotient bit per step.
    localparam int DVW = SUMW;
    localparam int DCW = $clog2(DVW + 1);
    logic [DVW-1:0] r_q, r_rem;
    logic [DVW-1:0] r_dvs;
    logic [DCW-1:0] r_dcnt;
    logic           r_dv_busy;
    logic [DVW:0]   w_trial;
    assign w_trial = {r_rem, r_q[DVW-1]} - (DVW+1)'(r_dvs);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
        end else if (i_cmd.dv_step) begin
            if (!r_dv_busy) begin
                r_dv_busy <= 1'b1;
                r_q       <= r_sum;
                r_rem     <= '0;
                r_dvs     <= DVW'(r_fk) * DVW'(r_fk);
                r_dcnt    <= '0;
            end else begin
                if (!w_trial[DVW]) begin
                    r_rem <= w_trial[DVW-1:0];
                    r_q   <= {r_q[DVW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DVW-2:0], r_q[DVW-1]};
                    r_q   <= {r_q[DVW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + DCW'(1);
                if (32'(r_dcnt) == DVW - 1) begin
                    r_dv_busy <= 1'b0;
                end
            end
        end
    end
    assign o_sts.dv_done = i_cmd.dv_step && r_dv_busy && (32'(r_dcnt) == DVW - 1);

    // Result select and output register.
    function automatic logic [SQW-1:0] w_trial_unused_sq(input logic [SQW-1:0] v,
            input logic [SQW-1:0] res, input logic [SQW-1:0] b);
        logic [SQW-1:0] r;
        r = (v >= res + b) ? ((res >> 1) + b) : (res >> 1);
        return r;
    endfunction
    logic [OUT_W-1:0] r_res;
    always_ff @(posedge i_clk) begin
        if (o_sts.sq_done) begin
            r_res <= OUT_W'(w_trial_unused_sq(r_sv, r_sres, r_sbit));
        end else if (o_sts.dv_done) begin
            r_res <= OUT_W'(w_trial[DVW] ? {r_q[DVW-2:0], 1'b0} : {r_q[DVW-2:0], 1'b1});
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid     <= 1'b1;
            o_pixel_out     <= r_res;
            o_last_of_frame <= r_last;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    `WFB_ASSERT_IMP(a_one_unit, i_clk, i_rst_n, 1'b1, !(r_sq_busy && r_dv_busy))
    `WFB_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, 1'b1, 32'(r_wslot) < ROWS)
    `WFB_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit, o_out_valid)
endmodule
`default_nettype wire

// File: hdl/window_filter_blur_or_sobel.sv
// Window filter top level: box blur or Sobel magnitude over a raster stream.
// One item at a time: an item without a result is stored and the block is ready again;
// an item with a result then runs the window walk over k*k elements (k = 3 for Sobel),
// the square root steps (Sobel) or the divide steps (blur), and loads the output register
// once the output is not stalled. The single line-store read port sets the walk.
// Synchronous active-low reset clears control and configuration; line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module window_filter_blur_or_sobel import wfb_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    wfb_cfg_if.sink   cfg,
    wfb_in_if.sink    in_ch,
    wfb_out_if.source out_ch
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_first;
    logic w_in_fire;

    assign cfg.ready = 1'b1;
    assign w_in_fire = in_ch.valid && in_ch.ready;

    // Sequencer.
    wfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_ch.valid && !out_ch.ready),
        .i_first    (w_first),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    wfb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg.valid),
        .i_cfg_index     (cfg.index),
        .i_cfg_data      (cfg.data),
        .i_in_fire       (w_in_fire),
        .i_pixel_in      (in_ch.pixel_in),
        .i_is_padding    (in_ch.is_padding),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_first         (w_first),
        .o_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .o_pixel_out     (out_ch.pixel_out),
        .o_last_of_frame (out_ch.last_of_frame)
    );
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the window filter (box blur or Sobel magnitude).
// Streams whole frames with random stalls and checks each output pixel against
// a built-in frame model. Depends on wfb_pkg, the wfb interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import wfb_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             pad;
    } t_pixel_item;

    typedef struct {
        logic [OUT_W-1:0] value;
        logic             last;
    } t_filtered;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wfb_cfg_if cfg_ch ();
    wfb_in_if  in_ch ();
    wfb_out_if out_ch ();

    window_filter_blur_or_sobel uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pixels waiting to be sent and filtered pixels still to come.
    t_pixel_item pixel_queue[$];
    t_filtered   filtered_queue[$];
    int          error_count = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          items_sent = 0;

    // Register shadows, as written through the configuration channel.
    logic        reg_mode;
    logic [2:0]  reg_kernel;
    logic [10:0] reg_width;
    logic [12:0] reg_height;

    // Frame model state: line store, raster position and latched frame setup.
    logic [7:0]  line_store[8][1024];
    int          col_pos, row_pos;
    logic        frm_mode;
    int          frm_k, frm_radius, frm_w, frm_h;

    function automatic int clamp_width(input logic [10:0] w);
        if (w == 0) return 1;
        if (w > 1024) return 1024;
        return w;
    endfunction

    function automatic int clamp_height(input logic [12:0] h);
        if (h == 0) return 1;
        if (h > 4096) return 4096;
        return h;
    endfunction

    function automatic int window_pixel(input int y, input int x);
        if (y < 0 || x < 0 || y >= frm_h || x >= frm_w) return 0;
        return line_store[y % 8][x];
    endfunction

    // Integer square root, one result bit at a time from the top.
    function automatic int int_sqrt(input int s);
        int r;
        r = 0;
        for (int b = 2048; b > 0; b = b >> 1)
            if ((r | b) * (r | b) <= s) r = r | b;
        return r;
    endfunction

    function automatic int filter_at(input int oy, input int ox);
        int gx, gy, sum;
        if (frm_mode) begin
            gx = (window_pixel(oy-1, ox+1) + 2*window_pixel(oy, ox+1) + window_pixel(oy+1, ox+1))
               - (window_pixel(oy-1, ox-1) + 2*window_pixel(oy, ox-1) + window_pixel(oy+1, ox-1));
            gy = (window_pixel(oy+1, ox-1) + 2*window_pixel(oy+1, ox) + window_pixel(oy+1, ox+1))
               - (window_pixel(oy-1, ox-1) + 2*window_pixel(oy-1, ox) + window_pixel(oy-1, ox+1));
            return int_sqrt(gx*gx + gy*gy);
        end
        sum = 0;
        for (int dy = -frm_radius; dy <= frm_radius; dy++)
            for (int dx = -frm_radius; dx <= frm_radius; dx++)
                sum += window_pixel(oy + dy, ox + dx);
        return sum / (frm_k * frm_k);
    endfunction

    // Advance the frame model by one accepted pixel and queue any output it causes.
    task automatic track_pixel(input logic [7:0] pix, input logic pad);
        int pos, delay, o;
        t_filtered res;
        if (row_pos == 0 && col_pos == 0) begin
            frm_w = clamp_width(reg_width);
            frm_h = clamp_height(reg_height);
            frm_mode = reg_mode;
            frm_k = reg_kernel;
            frm_radius = reg_mode ? 1 : (frm_k - 1) / 2;
        end
        if (row_pos < frm_h) line_store[row_pos % 8][col_pos] = pad ? 8'd0 : pix;
        pos = row_pos * frm_w + col_pos;
        delay = frm_radius * frm_w + frm_radius;
        col_pos++;
        if (col_pos >= frm_w) begin
            col_pos = 0;
            row_pos++;
        end
        if (pos >= delay) begin
            o = pos - delay;
            res.value = OUT_W'(filter_at(o / frm_w, o % frm_w));
            res.last = (o == frm_w * frm_h - 1);
            filtered_queue.push_back(res);
            if (res.last) begin
                col_pos = 0;
                row_pos = 0;
            end
        end
    endtask

    // Pixel driver; the model is updated on each accepted transfer.
    always @(posedge i_clk) begin : pixel_driver
        t_pixel_item item;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) track_pixel(in_ch.pixel_in, in_ch.is_padding);
            if (!in_ch.valid || in_ch.ready) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    item = pixel_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.pixel_in <= item.pix;
                    in_ch.is_padding <= item.pad;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output ready with random stalls and, on request, one long hold-off.
    always @(posedge i_clk) begin : output_sink
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = 400;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output checker against the oldest expected pixel.
    always @(posedge i_clk) begin : output_check
        t_filtered want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (filtered_queue.size() == 0) begin
                $display("%0t: unexpected output pixel %0d last %0b", $time,
                         out_ch.pixel_out, out_ch.last_of_frame);
                error_count++;
            end else begin
                want = filtered_queue.pop_front();
                if (out_ch.pixel_out !== want.value) begin
                    $display("%0t: pixel_out expected %0d actual %0d", $time,
                             want.value, out_ch.pixel_out);
                    error_count++;
                end
                if (out_ch.last_of_frame !== want.last) begin
                    $display("%0t: last_of_frame expected %0b actual %0b", $time,
                             want.last, out_ch.last_of_frame);
                    error_count++;
                end
            end
        end
    end

    // One register write; the shadow follows the register rules.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MODE: reg_mode = data[0];
            REG_KERNEL: if (data[0]) reg_kernel = data[2:0];
            REG_WIDTH: reg_width = data[10:0];
            REG_HEIGHT: reg_height = data[12:0];
            default: ;
        endcase
    endtask

    task automatic setup(input logic mode, input int k, input int w, input int h);
        write_reg(REG_MODE, CFG_DAT_W'(mode));
        write_reg(REG_KERNEL, CFG_DAT_W'(k));
        write_reg(REG_WIDTH, CFG_DAT_W'(w));
        write_reg(REG_HEIGHT, CFG_DAT_W'(h));
    endtask

    // Queue one frame plus its flush items; style picks the pixel content.
    task automatic queue_frame(input int style);
        int w, h, r, n;
        t_pixel_item item;
        w = clamp_width(reg_width);
        h = clamp_height(reg_height);
        r = reg_mode ? 1 : (reg_kernel - 1) / 2;
        n = w * h + r * w + r;
        for (int i = 0; i < n; i++) begin
            item.pix = $urandom_range(255);
            item.pad = 1'b0;
            if (i >= w * h) item.pad = $urandom_range(1);
            else if (style == 1) item.pix = 8'hFF;
            else if (style == 2) item.pix = ((i + i / w) % 2) ? 8'hFF : 8'h00;
            else if (style == 3) item.pad = ($urandom_range(99) < 15);
            pixel_queue.push_back(item);
        end
        items_sent += n;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
            default: begin send_gap_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // Wait until every pixel went in and every output came back, then let the block settle.
    task automatic drain;
        while (pixel_queue.size() > 0 || in_ch.valid || filtered_queue.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_frame(input logic mode, input int k, input int w, input int h,
                             input int style, input int phase);
        setup(mode, k, w, h);
        set_idling(phase);
        queue_frame(style);
        drain();
    endtask

    initial begin : stimulus
        int frame_no;
        logic [2:0] kern;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MODE;
        cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.is_padding = 1'b0;
        out_ch.ready = 1'b0;
        reg_mode = 1'b0;
        reg_kernel = 3'd3;
        reg_width = 11'd1024;
        reg_height = 13'd1024;
        col_pos = 0;
        row_pos = 0;
        foreach (line_store[i, j]) line_store[i][j] = 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: kernel extremes, saturated and alternating content, padding.
        run_frame(1'b0, 1, 4, 3, 1, 0);
        run_frame(1'b0, 3, 5, 4, 2, 1);
        run_frame(1'b0, 7, 8, 7, 1, 2);
        run_frame(1'b1, 3, 6, 5, 2, 3);
        run_frame(1'b1, 7, 4, 4, 3, 0);
        // Even kernel writes leave the last odd kernel in place.
        write_reg(REG_KERNEL, CFG_DAT_W'(4));
        write_reg(REG_KERNEL, CFG_DAT_W'(0));
        run_frame(1'b0, 5, 6, 6, 3, 0);
        // Zero width and height both count as one: a single-pixel frame.
        run_frame(1'b0, 7, 0, 0, 1, 1);
        run_frame(1'b1, 3, 1, 1, 1, 2);

        // Random frames, mostly small, with a long output hold-off early on.
        frame_no = 0;
        while (items_sent < 450) begin
            kern = 2 * $urandom_range(3) + 1;
            setup($urandom_range(1), kern, $urandom_range(12, 1), $urandom_range(8, 1));
            set_idling(frame_no);
            queue_frame($urandom_range(3));
            if (frame_no == 2) begin
                send_gap_pct = 0;
                hold_request++;
            end
            drain();
            frame_no++;
        end

        if (error_count == 0)
            $display("window_filter_blur_or_sobel verification clean");
        else
            $display("window_filter_blur_or_sobel verification failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("window_filter_blur_or_sobel verification failed");
        $finish;
    end
endmodule
`default_nettype wire
